/* rtl/ugse_pkg.sv */
// Package for the undirected graph statistics engine.
// Holds shared constants and the sequencer state type; no dependencies.
package ugse_pkg;

    localparam int MaxVerts = 16;
    localparam logic [15:0] AbsentWeight = 16'd9999;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DFS_ROOT,
        ST_DFS_STEP,
        ST_DONE
    } t_state;

endpackage

/* rtl/undirected_graph_stats_engine.sv */
// Undirected graph statistics engine: presence matrix, row statistics and DFS cycle search.
// Sequence from acceptance to the strobe: an update, a row scan, a DFS cycle search
// and a done state; a cycle found ends the search early.
// Busy throughout, one transaction at a time; the next is accepted in the cycle after the strobe.
// Synchronous active-low reset clears control, vertex count and the matrix at once.
// Depends on ugse_pkg.
module undirected_graph_stats_engine #(
    parameter int MAX_VERTS = ugse_pkg::MaxVerts
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [3:0]  i_source_vertex,
    input  logic [3:0]  i_target_vertex,
    input  logic signed [15:0] i_edge_weight,
    output logic        o_strobe,
    output logic        o_bad_vertex,
    output logic [4:0]  o_vertices_reported,
    output logic [6:0]  o_edge_total,
    output logic        o_has_cycle,
    output logic [4:0]  o_odd_degree_total,
    output logic [4:0]  o_even_degree_total,
    output logic        o_is_complete
);
    localparam int VW = $clog2(MAX_VERTS);
    localparam int NW = $clog2(MAX_VERTS + 1);
    localparam int EW = $clog2(MAX_VERTS * (MAX_VERTS - 1) / 2 + 1);

    ugse_pkg::t_state r_state, n_state;

    logic [MAX_VERTS-1:0] r_adj [MAX_VERTS];
    logic [4:0]    r_vcount;
    logic [NW-1:0] n_used;
    logic          r_op;
    logic [3:0]    r_src, r_tgt;
    logic [15:0]   r_wt;
    logic          r_bad;
    logic [VW:0]   r_row;
    logic [EW-1:0] r_edges;
    logic [NW-1:0] r_odd, r_even;
    logic [MAX_VERTS-1:0] r_vis;
    // Stack frame: vertex, parent with a valid flag, next column.
    logic [VW-1:0] r_stk_v   [MAX_VERTS];
    logic [VW-1:0] r_stk_p   [MAX_VERTS];
    logic          r_stk_hp  [MAX_VERTS];
    logic [VW:0]   r_stk_nx  [MAX_VERTS];
    logic [VW:0]   r_depth;
    logic          r_cyc;

    logic [MAX_VERTS-1:0] w_mask, w_row;
    logic [EW-1:0] w_upper;
    logic [VW-1:0] w_top;
    logic [VW-1:0] w_cv, w_cp;
    logic          w_chp;
    logic [VW:0]   w_cnx;
    logic [EW-1:0] w_full;
    logic          w_src_ok, w_tgt_ok;

    always_comb begin
        if (int'(r_vcount) > MAX_VERTS) n_used = NW'(MAX_VERTS);
        else n_used = NW'(r_vcount);
    end

    always_comb begin
        for (int k = 0; k < MAX_VERTS; k++) w_mask[k] = (k < int'(n_used));
    end

    assign w_src_ok = (int'(r_src) < int'(n_used)) && (int'(r_src) < MAX_VERTS);
    assign w_tgt_ok = (int'(r_tgt) < int'(n_used)) && (int'(r_tgt) < MAX_VERTS);

    // Row under scan, restricted to columns in use; upper part counts edges.
    always_comb begin
        w_row = r_adj[r_row[VW-1:0]] & w_mask;
        w_upper = '0;
        for (int k = 0; k < MAX_VERTS; k++)
            if (k > int'(r_row)) w_upper = w_upper + EW'(w_row[k]);
    end

    assign w_top = VW'(r_depth - 1'b1);
    assign w_cv  = r_stk_v[w_top];
    assign w_cp  = r_stk_p[w_top];
    assign w_chp = r_stk_hp[w_top];
    assign w_cnx = r_stk_nx[w_top];
    assign w_full = EW'((32'(n_used) * (32'(n_used) - 1)) >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ugse_pkg::ST_IDLE:     if (start) n_state = ugse_pkg::ST_UPDATE;
            ugse_pkg::ST_UPDATE:   n_state = ugse_pkg::ST_SCAN;
            ugse_pkg::ST_SCAN:
                if (r_row >= (VW+1)'(n_used)) n_state = ugse_pkg::ST_DFS_ROOT;
            ugse_pkg::ST_DFS_ROOT: begin
                if (r_cyc || r_row >= (VW+1)'(n_used)) n_state = ugse_pkg::ST_DONE;
                else if (!r_vis[r_row[VW-1:0]]) n_state = ugse_pkg::ST_DFS_STEP;
            end
            ugse_pkg::ST_DFS_STEP: begin
                if (r_depth == '0) n_state = ugse_pkg::ST_DFS_ROOT;
                else if (w_cnx < (VW+1)'(n_used) && r_adj[w_cv][w_cnx[VW-1:0]]
                         && r_vis[w_cnx[VW-1:0]]
                         && !(w_chp && w_cp == w_cnx[VW-1:0]))
                    n_state = ugse_pkg::ST_DONE;
            end
            ugse_pkg::ST_DONE:     n_state = ugse_pkg::ST_IDLE;
            default:               n_state = ugse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = (r_state != ugse_pkg::ST_IDLE);
        o_strobe = (r_state == ugse_pkg::ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ugse_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            for (int k = 0; k < MAX_VERTS; k++) r_adj[k] <= '0;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
            for (int k = 0; k < MAX_VERTS; k++) r_adj[k] <= '0;
        end else if (r_state == ugse_pkg::ST_UPDATE && !r_op && w_src_ok && w_tgt_ok) begin
            r_adj[VW'(r_src)][VW'(r_tgt)] <= (r_wt != ugse_pkg::AbsentWeight);
            r_adj[VW'(r_tgt)][VW'(r_src)] <= (r_wt != ugse_pkg::AbsentWeight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_vis   <= '0;
            r_cyc   <= 1'b0;
        end else begin
            case (r_state)
                ugse_pkg::ST_IDLE: if (start) begin
                    r_op  <= i_op;
                    r_src <= i_source_vertex;
                    r_tgt <= i_target_vertex;
                    r_wt  <= i_edge_weight;
                end
                ugse_pkg::ST_UPDATE: begin
                    r_bad   <= !r_op && !(w_src_ok && w_tgt_ok);
                    r_row   <= '0;
                    r_edges <= '0;
                    r_odd   <= '0;
                    r_even  <= '0;
                end
                ugse_pkg::ST_SCAN: begin
                    if (r_row < (VW+1)'(n_used)) begin
                        r_edges <= r_edges + w_upper;
                        if (^w_row) r_odd <= r_odd + 1'b1;
                        else r_even <= r_even + 1'b1;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_row   <= '0;
                        r_vis   <= '0;
                        r_depth <= '0;
                        r_cyc   <= 1'b0;
                    end
                end
                ugse_pkg::ST_DFS_ROOT: begin
                    if (r_row < (VW+1)'(n_used) && !r_cyc) begin
                        if (!r_vis[r_row[VW-1:0]]) begin
                            r_stk_v[0]  <= r_row[VW-1:0];
                            r_stk_hp[0] <= 1'b0;
                            r_stk_p[0]  <= '0;
                            r_stk_nx[0] <= '0;
                            r_depth     <= (VW+1)'(1);
                            r_vis[r_row[VW-1:0]] <= 1'b1;
                        end
                        r_row <= r_row + 1'b1;
                    end
                end
                ugse_pkg::ST_DFS_STEP: begin
                    if (r_depth != '0) begin
                        if (w_cnx >= (VW+1)'(n_used)) begin
                            r_depth <= r_depth - 1'b1;
                        end else begin
                            r_stk_nx[w_top] <= w_cnx + 1'b1;
                            if (r_adj[w_cv][w_cnx[VW-1:0]]) begin
                                if (!r_vis[w_cnx[VW-1:0]]) begin
                                    r_stk_v[r_depth[VW-1:0]]  <= w_cnx[VW-1:0];
                                    r_stk_p[r_depth[VW-1:0]]  <= w_cv;
                                    r_stk_hp[r_depth[VW-1:0]] <= 1'b1;
                                    r_stk_nx[r_depth[VW-1:0]] <= '0;
                                    r_depth <= r_depth + 1'b1;
                                    r_vis[w_cnx[VW-1:0]] <= 1'b1;
                                end else if (!(w_chp && w_cp == w_cnx[VW-1:0])) begin
                                    r_cyc <= 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // A new vertex is pushed only when unvisited, so depth never exceeds the vertex count.
    always_comb begin
        o_bad_vertex        = r_bad;
        o_vertices_reported = 5'(n_used);
        o_edge_total        = 7'(r_edges);
        o_has_cycle         = r_cyc;
        o_odd_degree_total  = 5'(r_odd);
        o_even_degree_total = 5'(r_even);
        o_is_complete       = (r_edges == w_full);
    end

endmodule
